FILE: design/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types, constants and rounding tables of the baud divisor calculator.
// ----------------------------------------------------------------------------
package bdc_pkg;

    // Widths of the request, the scaled rate and the datapath
    localparam int REQ_W  = 24;
    localparam int BAUD_W = 26;
    localparam int NUM_W  = 28;
    localparam int DEN_W  = 18;
    localparam int CAND_W = 18;
    localparam int ENC_W  = 18;
    localparam int EST_W  = 24;
    localparam int CFG_W  = 3;
    localparam int CIDX_W = 2;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CHIP_CLASS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BITBANG    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PORT_INDEX = 2'd2;

    // Chip classes
    localparam logic [1:0] CLASS_OLD = 2'd0;
    localparam logic [1:0] CLASS_STD = 2'd1;
    localparam logic [1:0] CLASS_HS  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Fixed divisor codes for the fastest rates
    localparam logic [1:0] QENC_FULL  = 2'd0;
    localparam logic [1:0] QENC_THIRD = 2'd1;
    localparam logic [1:0] QENC_HALF  = 2'd2;

    // Sixteen times the clock over the prescaler
    localparam logic [NUM_W-1:0] NUM_HS  = 28'd192000000;
    localparam logic [NUM_W-1:0] NUM_STD = 28'd48000000;
    localparam logic [NUM_W-1:0] NUM_OLD = 28'd24000000;

    // High-speed chips fall back to 48 MHz at or below this rate
    localparam logic [BAUD_W-1:0] HS_LOW_MAX = 26'd732;

    localparam logic [EST_W-1:0] HS_RATE_FULL  = 24'd12000000;
    localparam logic [EST_W-1:0] HS_RATE_THIRD = 24'd8000000;
    localparam logic [EST_W-1:0] HS_RATE_HALF  = 24'd6000000;
    localparam logic [EST_W-1:0] STD_RATE_FULL  = 24'd3000000;
    localparam logic [EST_W-1:0] STD_RATE_THIRD = 24'd2000000;
    localparam logic [EST_W-1:0] STD_RATE_HALF  = 24'd1500000;

    localparam logic [NUM_W-1:0]  BEST_LIMIT = 28'h20000;
    localparam logic [CAND_W-1:0] BEST_CLAMP = 18'h1FFFF;
    localparam logic [BAUD_W-1:0] OLD_T_MIN    = 26'd8;
    localparam logic [BAUD_W-1:0] OLD_BASE_MIN = 26'd16;
    localparam logic [BAUD_W-1:0] OLD_T_MAX    = 26'h1FFF8;

    localparam logic [ENC_W-1:0] ENC_HS_FLAG  = 18'h20000;
    localparam logic [ENC_W-1:0] ENC_OLD_ONE  = 18'h00001;
    localparam logic [ENC_W-1:0] ENC_OLD_4001 = 18'h04001;

    // One accepted request, classified
    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic              zero;
        logic              hs_fmt;
        logic              hs_hi;
        logic              old;
        logic              quick;
        logic [1:0]        quick_enc;
        logic [EST_W-1:0]  quick_est;
        logic [2:0]        port;
    } t_item;

    // Request plus its first divisor candidate
    typedef struct packed {
        t_item             item;
        logic [CAND_W-1:0] cand0;
    } t_mid;

    // Fraction code of the low three divisor bits
    function automatic logic [2:0] frac_map(input logic [2:0] i_sel);
        logic [2:0] v;
        case (i_sel)
            3'd0: v = 3'd0;
            3'd1: v = 3'd3;
            3'd2: v = 3'd2;
            3'd3: v = 3'd4;
            3'd4: v = 3'd1;
            3'd5: v = 3'd5;
            3'd6: v = 3'd6;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] old_round_up(input logic [2:0] i_sel);
        logic [2:0] v;
        case (i_sel)
            3'd3: v = 3'd1;
            3'd5: v = 3'd3;
            3'd6: v = 3'd2;
            3'd7: v = 3'd1;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] old_round_dn(input logic [2:0] i_sel);
        logic [2:0] v;
        case (i_sel)
            3'd3: v = 3'd1;
            3'd5: v = 3'd1;
            3'd6: v = 3'd2;
            3'd7: v = 3'd3;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Divisor to encoded form: whole part low, fraction code at bit 14
    function automatic logic [ENC_W-1:0] enc_of(input logic [CAND_W-1:0] i_best);
        return {3'b000, i_best[CAND_W-1:3]} | {1'b0, frac_map(i_best[2:0]), 14'd0};
    endfunction

endpackage

FILE: design/bdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_div
// Pipelined restoring divider: one quotient bit per stage, one word per cycle.
// ----------------------------------------------------------------------------
module bdc_div
    import bdc_pkg::*;
#(
    parameter int WN = NUM_W,
    parameter int WD = BAUD_W,
    parameter int WS = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    input  logic [WS-1:0] i_side,
    output logic          o_valid,
    output logic [WN-1:0] o_quo,
    output logic [WS-1:0] o_side
);

    logic          r_vld  [0:WN-1];
    logic [WD-1:0] r_rem  [0:WN-1];
    logic [WN-1:0] r_num  [0:WN-1];
    logic [WN-1:0] r_quo  [0:WN-1];
    logic [WD-1:0] r_den  [0:WN-1];
    logic [WS-1:0] r_side [0:WN-1];

    for (genvar k = 0; k < WN; k++) begin : g_stage
        logic          w_vld;
        logic [WD-1:0] w_rem;
        logic [WD-1:0] w_den;
        logic [WN-1:0] w_num;
        logic [WN-1:0] w_quo;
        logic [WS-1:0] w_side;
        logic [WD:0]   w_try;
        logic          w_ge;
        logic [WD-1:0] n_rem;

        if (k == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        // Bring down the next numerator bit and try the subtract
        assign w_try = {w_rem, w_num[WN-1]};
        assign w_ge  = (w_try >= {1'b0, w_den});
        assign n_rem = w_ge ? WD'(w_try - {1'b0, w_den}) : WD'(w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_num[k]  <= {w_num[WN-2:0], 1'b0};
            r_quo[k]  <= {w_quo[WN-2:0], w_ge};
            r_den[k]  <= w_den;
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_vld[WN-1];
    assign o_quo   = r_quo[WN-1];
    assign o_side  = r_side[WN-1];

endmodule

FILE: design/bdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_front
// Configuration registers; accepts requests, scales and classifies them.
// ----------------------------------------------------------------------------
module bdc_front
    import bdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_start,
    input  logic [REQ_W-1:0]  i_baud_request,
    input  logic              i_full,
    output logic              o_push,
    output t_item             o_item
);

    logic [1:0] r_chip_class;
    logic       r_bitbang_on;
    logic [2:0] r_port_index;

    logic [BAUD_W-1:0] w_baud;
    logic              w_hs;
    logic              w_std;
    logic              w_old;
    logic              w_hs_hi;
    logic              w_quick;
    logic [1:0]        w_qenc;
    logic [EST_W-1:0]  w_qest;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_class <= CLASS_STD;
            r_bitbang_on <= 1'b0;
            r_port_index <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHIP_CLASS: r_chip_class <= i_cfg_data[1:0];
                CFG_BITBANG:    r_bitbang_on <= i_cfg_data[0];
                CFG_PORT_INDEX: r_port_index <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Scale for bitbang and pick the clock path
    assign w_baud  = r_bitbang_on ? {i_baud_request, 2'b00} : {2'b00, i_baud_request};
    assign w_hs    = (r_chip_class == CLASS_HS);
    assign w_std   = (r_chip_class == CLASS_STD);
    assign w_old   = !w_hs && !w_std;
    assign w_hs_hi = w_hs && (w_baud > HS_LOW_MAX);

    // Catch the three fastest rates of high-speed and standard chips, which need no division
    always_comb begin
        w_quick = 1'b0;
        w_qenc  = QENC_FULL;
        w_qest  = '0;
        if (w_hs_hi) begin
            if (w_baud >= {2'b00, HS_RATE_FULL}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_FULL;
                w_qest  = HS_RATE_FULL;
            end else if (w_baud >= {2'b00, HS_RATE_THIRD}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_THIRD;
                w_qest  = HS_RATE_THIRD;
            end else if (w_baud >= {2'b00, HS_RATE_HALF}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_HALF;
                w_qest  = HS_RATE_HALF;
            end
        end else if (!w_old) begin
            if (w_baud >= {2'b00, STD_RATE_FULL}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_FULL;
                w_qest  = STD_RATE_FULL;
            end else if (w_baud >= {2'b00, STD_RATE_THIRD}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_THIRD;
                w_qest  = STD_RATE_THIRD;
            end else if (w_baud >= {2'b00, STD_RATE_HALF}) begin
                w_quick = 1'b1;
                w_qenc  = QENC_HALF;
                w_qest  = STD_RATE_HALF;
            end
        end
    end

    assign o_push = i_start && !i_full;

    always_comb begin
        o_item.baud      = w_baud;
        o_item.zero      = (w_baud == '0);
        o_item.hs_fmt    = w_hs;
        o_item.hs_hi     = w_hs_hi;
        o_item.old       = w_old;
        o_item.quick     = w_quick;
        o_item.quick_enc = w_qenc;
        o_item.quick_est = w_qest;
        o_item.port      = r_port_index;
    end

endmodule

FILE: design/bdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_queue
// Short queue of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module bdc_queue
    import bdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [0:DEPTH-1];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_item  = r_mem[r_rd];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/bdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_back
// Divides out the divisor, picks the candidate, encodes it and grades it.
// ----------------------------------------------------------------------------
module bdc_back
    import bdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_valid,
    output logic [15:0]       o_divisor_value,
    output logic [15:0]       o_divisor_index,
    output logic [EST_W-1:0]  o_actual_baud,
    output logic [1:0]        o_status
);

    // Old-class candidate from the rounded-down base
    function automatic logic [CAND_W-1:0] old_cand(input logic [BAUD_W-1:0] i_base,
                                                   input logic [BAUD_W-1:0] i_t);
        logic [BAUD_W-1:0] t2;
        logic [CAND_W-1:0] v;
        t2 = i_t + BAUD_W'(old_round_up(i_t[2:0]));
        if (i_t <= OLD_T_MIN) begin
            v = CAND_W'(OLD_T_MIN);
        end else if (i_base < OLD_BASE_MIN) begin
            v = CAND_W'(OLD_BASE_MIN);
        end else if (t2 > OLD_T_MAX) begin
            v = CAND_W'(OLD_T_MAX);
        end else begin
            v = t2[CAND_W-1:0];
        end
        return v;
    endfunction

    function automatic logic [BAUD_W-1:0] abs_diff(input logic [BAUD_W-1:0] i_a,
                                                   input logic [EST_W-1:0]  i_e);
        logic [BAUD_W-1:0] e;
        e = {2'b00, i_e};
        return (e < i_a) ? (i_a - e) : (e - i_a);
    endfunction

    // ---------------- first division: clock over rate ----------------
    logic [NUM_W-1:0]  w_num1;
    logic [BAUD_W-1:0] w_den1;
    logic              w_d1_vld;
    logic [NUM_W-1:0]  w_d1_quo;
    t_item             w_d1_item;

    assign w_num1 = i_item.old   ? NUM_OLD :
                    i_item.hs_hi ? NUM_HS  : NUM_STD;
    assign w_den1 = i_item.zero ? BAUD_W'(1) : i_item.baud;

    bdc_div #(.WN(NUM_W), .WD(BAUD_W), .WS($bits(t_item))) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .i_side  (i_item),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_item)
    );

    // ---------------- candidates ----------------
    logic [NUM_W-1:0]  w_best_r;
    logic [CAND_W-1:0] w_best;
    logic [BAUD_W-1:0] w_base;
    logic [CAND_W-1:0] w_oc0;
    logic [CAND_W-1:0] w_oc1;

    assign w_best_r = NUM_W'(({1'b0, w_d1_quo} + (NUM_W + 1)'(1)) >> 1);

    always_comb begin
        if (w_best_r > BEST_LIMIT) begin
            w_best = BEST_CLAMP;
        end else if (w_best_r == '0) begin
            w_best = CAND_W'(1);
        end else begin
            w_best = w_best_r[CAND_W-1:0];
        end
    end

    assign w_base = {1'b0, w_d1_quo[BAUD_W-2:0]} - BAUD_W'(old_round_dn(w_d1_quo[2:0]));
    assign w_oc0  = old_cand(w_base, w_base);
    assign w_oc1  = old_cand(w_base, w_base + BAUD_W'(1));

    logic              r_b_vld;
    logic [NUM_W-1:0]  r_b_num_a;
    logic [DEN_W-1:0]  r_b_den_a;
    t_mid              r_b_mid;
    logic [NUM_W-1:0]  r_b_num_b;
    logic [DEN_W-1:0]  r_b_den_b;

    // Hold the divisor candidates for the second division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mid.item <= w_d1_item;
        if (w_d1_item.old) begin
            r_b_num_a     <= NUM_OLD + NUM_W'(w_oc0 >> 1);
            r_b_den_a     <= w_oc0;
            r_b_mid.cand0 <= w_oc0;
        end else begin
            r_b_num_a     <= w_d1_item.hs_hi ? NUM_HS : NUM_STD;
            r_b_den_a     <= w_best;
            r_b_mid.cand0 <= w_best;
        end
        r_b_num_b <= NUM_OLD + NUM_W'(w_oc1 >> 1);
        r_b_den_b <= w_oc1;
    end

    // ---------------- second division: rate achieved ----------------
    logic              w_da_vld;
    logic [NUM_W-1:0]  w_da_quo;
    t_mid              w_da_mid;
    logic              w_db_vld;
    logic [NUM_W-1:0]  w_db_quo;
    logic [CAND_W-1:0] w_db_cand;

    bdc_div #(.WN(NUM_W), .WD(DEN_W), .WS($bits(t_mid))) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_num_a),
        .i_den   (r_b_den_a),
        .i_side  (r_b_mid),
        .o_valid (w_da_vld),
        .o_quo   (w_da_quo),
        .o_side  (w_da_mid)
    );

    bdc_div #(.WN(NUM_W), .WD(DEN_W), .WS(CAND_W)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_num_b),
        .i_den   (r_b_den_b),
        .i_side  (r_b_den_b),
        .o_valid (w_db_vld),
        .o_quo   (w_db_quo),
        .o_side  (w_db_cand)
    );

    // ---------------- pick and encode ----------------
    logic [EST_W-1:0]  w_est_clk;
    logic [EST_W-1:0]  w_est0;
    logic [EST_W-1:0]  w_est1;
    logic              w_pick1;
    logic [CAND_W-1:0] w_old_best;
    logic [ENC_W-1:0]  w_old_raw;
    logic [ENC_W-1:0]  w_enc;
    logic [EST_W-1:0]  w_actual;

    assign w_est_clk  = EST_W'(({1'b0, w_da_quo} + (NUM_W + 1)'(1)) >> 1);
    assign w_est0     = w_da_quo[EST_W-1:0];
    assign w_est1     = w_db_quo[EST_W-1:0];
    assign w_pick1    = abs_diff(w_da_mid.item.baud, w_est1)
                        < abs_diff(w_da_mid.item.baud, w_est0);
    assign w_old_best = w_pick1 ? w_db_cand : w_da_mid.cand0;
    assign w_old_raw  = enc_of(w_old_best);

    always_comb begin
        if (w_da_mid.item.old) begin
            w_actual = w_pick1 ? w_est1 : w_est0;
            if (w_old_raw == ENC_OLD_ONE) begin
                w_enc = '0;
            end else if (w_old_raw == ENC_OLD_4001) begin
                w_enc = ENC_OLD_ONE;
            end else begin
                w_enc = w_old_raw;
            end
        end else begin
            w_actual = w_da_mid.item.quick ? w_da_mid.item.quick_est : w_est_clk;
            w_enc    = w_da_mid.item.quick ? ENC_W'(w_da_mid.item.quick_enc)
                                           : enc_of(w_da_mid.cand0);
            if (w_da_mid.item.hs_hi) begin
                w_enc = w_enc | ENC_HS_FLAG;
            end
        end
    end

    logic              r_c_vld;
    logic [ENC_W-1:0]  r_c_enc;
    logic [EST_W-1:0]  r_c_actual;
    logic [BAUD_W-1:0] r_c_baud;
    logic              r_c_zero;
    logic              r_c_hs;
    logic [2:0]        r_c_port;

    // Hold the chosen divisor and rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_da_vld && w_db_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_enc    <= w_enc;
        r_c_actual <= w_actual;
        r_c_baud   <= w_da_mid.item.baud;
        r_c_zero   <= w_da_mid.item.zero;
        r_c_hs     <= w_da_mid.item.hs_fmt;
        r_c_port   <= w_da_mid.item.port;
    end

    // ---------------- format and tolerance ----------------
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_a20;
    logic [31:0] w_b20;
    logic        w_range;
    logic [15:0] w_idx;

    assign w_a   = {8'd0, r_c_actual};
    assign w_b   = {6'd0, r_c_baud};
    assign w_a20 = (w_a << 4) + (w_a << 2);
    assign w_b20 = (w_b << 4) + (w_b << 2);
    assign w_range = ((w_a << 1) < w_b)
                     || ((w_a < w_b) ? ((w_a20 + w_a) < w_b20) : ((w_b20 + w_b) < w_a20));
    assign w_idx = r_c_hs ? {6'd0, r_c_enc[17:16], 5'd0, r_c_port}
                          : {14'd0, r_c_enc[17:16]};

    logic              r_out_vld;
    logic [15:0]       r_out_value;
    logic [15:0]       r_out_idx;
    logic [EST_W-1:0]  r_out_actual;
    logic [1:0]        r_out_status;

    // Drive the result word for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_zero) begin
            r_out_value  <= '0;
            r_out_idx    <= '0;
            r_out_actual <= '0;
            r_out_status <= ST_INVALID;
        end else begin
            r_out_value  <= r_c_enc[15:0];
            r_out_idx    <= w_idx;
            r_out_actual <= r_c_actual;
            r_out_status <= w_range ? ST_RANGE : ST_OK;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_divisor_value = r_out_value;
    assign o_divisor_index = r_out_idx;
    assign o_actual_baud   = r_out_actual;
    assign o_status        = r_out_status;

    // An invalid request carries no divisor and no rate
    a_invalid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_status == ST_INVALID)
        |-> (r_out_value == '0) && (r_out_idx == '0) && (r_out_actual == '0))
        else $error("invalid request word carries nonzero fields");

    // Only high-speed chips set the upper divisor flag
    a_hs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld && !r_c_hs |-> !r_c_enc[ENC_W-1])
        else $error("high-speed flag set on a non high-speed chip");

    // An accepted word always reports a nonzero rate
    a_ok_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_status == ST_OK) |-> (r_out_actual != '0))
        else $error("accepted word with zero achieved rate");

    // Both second-stage lanes move in lockstep
    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_da_vld == w_db_vld)
        else $error("divider lanes out of step");

endmodule

FILE: design/uart_baud_divisor_calc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core
// Turns a requested baud rate into the encoded fractional divisor of a USB
// serial bridge, with the achieved rate and a tolerance status.
// ----------------------------------------------------------------------------
// Pulse start with a rate while busy is low; one request can be taken every
// clock cycle. Each result appears on the o_ ports for a single cycle with
// o_valid high, in request order, after its request has passed the queue stage,
// two 28-stage pipelined dividers in series (clock over rate, then clock over
// the chosen divisor) and three register stages around them. The receiver cannot
// hold results off, so it must take every o_valid cycle. Write configuration
// only while no request is in flight; a request uses the settings present
// when it is taken.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core
    import bdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  i_baud_request,
    output logic              o_valid,
    output logic [15:0]       o_divisor_value,
    output logic [15:0]       o_divisor_index,
    output logic [EST_W-1:0]  o_actual_baud,
    output logic [1:0]        o_status
);

    logic  w_push;
    t_item w_front_item;
    logic  w_q_valid;
    logic  w_q_full;
    t_item w_q_item;

    assign busy = w_q_full;

    // Accept and classify requests
    bdc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_baud_request (i_baud_request),
        .i_full         (w_q_full),
        .o_push         (w_push),
        .o_item         (w_front_item)
    );

    // Decouple front and back
    bdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_q_valid),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    // Compute, encode and grade
    bdc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_item          (w_q_item),
        .o_valid         (o_valid),
        .o_divisor_value (o_divisor_value),
        .o_divisor_index (o_divisor_index),
        .o_actual_baud   (o_actual_baud),
        .o_status        (o_status)
    );

endmodule
